/* rtl/mbcd_pkg.sv */
// Shared types and constants for the multiplexed BCD display driver.
// No dependencies; used by every module of the block.
`default_nettype none
package mbcd_pkg;

	localparam int VALUE_W       = 32;
	localparam int NUM_CELLS     = 10;  // decimal digits of a 32-bit value
	localparam int BITS_PER_STEP = 4;   // shift-add-3 steps done per cycle
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(STEPS);
	localparam int IDX_W         = $clog2(NUM_CELLS);
	localparam int NIB_W         = 4;
	localparam int SEL_W         = 3;
	localparam int CNT_W         = 4;

	typedef logic [NIB_W-1:0]         nib_t;
	typedef logic [BITS_PER_STEP-1:0] carry_t;

	typedef struct packed {
		logic load;   // clear cells, capture value
		logic shift;  // run one group of shift-add-3 steps
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/mbcd_cell.sv */
// One BCD digit cell of the shift-add-3 chain.
// Depends on mbcd_pkg.
`default_nettype none
module mbcd_cell (
	input  wire logic            clk,
	input  wire mbcd_pkg::ctl_t   ctl,
	input  wire mbcd_pkg::carry_t carry_in,
	output mbcd_pkg::carry_t      carry_out,
	output mbcd_pkg::nib_t        digit
);

	mbcd_pkg::nib_t digit_q;
	mbcd_pkg::nib_t digit_d;

	// bit j of carry_in enters at sub-step j; carry_out[j] is what leaves then
	always_comb begin
		mbcd_pkg::nib_t v;
		mbcd_pkg::nib_t a;
		v = digit_q;
		a = '0;
		carry_out = '0;
		for (int j = 0; j < mbcd_pkg::BITS_PER_STEP; j++) begin
			a = (v >= mbcd_pkg::nib_t'(5)) ? v + mbcd_pkg::nib_t'(3) : v;
			carry_out[j] = a[mbcd_pkg::NIB_W-1];
			v = {a[mbcd_pkg::NIB_W-2:0], carry_in[j]};
		end
		digit_d = v;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			digit_q <= '0;
		end else if (ctl.shift) begin
			digit_q <= digit_d;
		end
	end

	assign digit = digit_q;

endmodule
`default_nettype wire

/* rtl/mbcd_chain.sv */
// Value shift register feeding a row of BCD cells (double dabble).
// Depends on mbcd_pkg and mbcd_cell.
`default_nettype none
module mbcd_chain (
	input  wire logic                                           clk,
	input  wire mbcd_pkg::ctl_t                                  ctl,
	input  wire logic [mbcd_pkg::VALUE_W-1:0]                    value,
	output logic [mbcd_pkg::NUM_CELLS-1:0][mbcd_pkg::NIB_W-1:0]  digits
);

	logic [mbcd_pkg::VALUE_W-1:0] value_q;
	mbcd_pkg::carry_t             carry_head;
	mbcd_pkg::carry_t             carry [mbcd_pkg::NUM_CELLS];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= value;
		end else if (ctl.shift) begin
			value_q <= value_q << mbcd_pkg::BITS_PER_STEP;
		end
	end

	// MSB of the value enters the low cell first
	always_comb begin
		for (int j = 0; j < mbcd_pkg::BITS_PER_STEP; j++) begin
			carry_head[j] = value_q[mbcd_pkg::VALUE_W-1-j];
		end
	end

	assign carry[0] = carry_head;

	for (genvar i = 0; i < mbcd_pkg::NUM_CELLS; i++) begin : g_cell
		if (i < mbcd_pkg::NUM_CELLS - 1) begin : g_mid
			mbcd_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.carry_in  (carry[i]),
				.carry_out (carry[i+1]),
				.digit     (digits[i])
			);
		end else begin : g_top
			mbcd_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.carry_in  (carry[i]),
				.carry_out (),
				.digit     (digits[i])
			);
		end
	end

endmodule
`default_nettype wire

/* rtl/multiplexed_bcd_display_driver.sv */
// Top level: binary-to-BCD conversion and digit strobing for a muxed display.
// Depends on mbcd_pkg and mbcd_chain.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | value
//   out     | output    | out_valid / out_stall | bcd_digit, digit_select, too_large, last
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (digit_count)
//
// An item is accepted in ST_IDLE, converted in the cell row in ST_CONV (4 shift-add-3
// steps per cycle over 32 bits), then shown in ST_SHOW as one result per digit of the
// clamped digit count, or as a single overflow result.
// One item is worked on at a time; a new item is taken while the last result
// still sits in the output register. out_stall only delays the strobe phase.
// Reset clears the control state and sets digit_count to 3.
`default_nettype none
module multiplexed_bcd_display_driver #(
	parameter int MAX_DIGITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [mbcd_pkg::CNT_W-1:0]          cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [mbcd_pkg::VALUE_W-1:0]        value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [mbcd_pkg::NIB_W-1:0]               bcd_digit,
	output logic [mbcd_pkg::SEL_W-1:0]               digit_select,
	output logic                                     too_large,
	output logic                                     last
);

	localparam logic [mbcd_pkg::CNT_W-1:0] MAX_N = mbcd_pkg::CNT_W'(MAX_DIGITS);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SHOW} state_t;

	state_t                                             state_q;
	logic [mbcd_pkg::CNT_W-1:0]                         dc_q;
	logic [mbcd_pkg::STEP_W-1:0]                        step_q;
	logic [mbcd_pkg::IDX_W-1:0]                         pos_q;
	logic [mbcd_pkg::SEL_W-1:0]                         sel_q;
	logic                                               out_valid_q;
	mbcd_pkg::nib_t                                     bcd_digit_q;
	logic [mbcd_pkg::SEL_W-1:0]                         digit_select_q;
	logic                                               too_large_q;
	logic                                               last_q;

	mbcd_pkg::ctl_t                                     ctl;
	logic [mbcd_pkg::NUM_CELLS-1:0][mbcd_pkg::NIB_W-1:0] digits;
	logic [mbcd_pkg::CNT_W-1:0]                         n_eff;
	logic                                               big;
	logic                                               in_xfer;
	logic                                               out_free;

	assign in_xfer  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign ctl.load  = in_xfer;
	assign ctl.shift = (state_q == ST_CONV);

	always_comb begin
		if (dc_q == '0) begin
			n_eff = mbcd_pkg::CNT_W'(1);
		end else if (dc_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = dc_q;
		end
	end

	// overflow: a nonzero digit at or above the displayed width
	always_comb begin
		big = 1'b0;
		for (int i = 0; i < mbcd_pkg::NUM_CELLS; i++) begin
			if (mbcd_pkg::CNT_W'(i) >= n_eff && digits[i] != '0) begin
				big = 1'b1;
			end
		end
	end

	mbcd_chain u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.value  (value),
		.digits (digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			dc_q           <= mbcd_pkg::CNT_W'(3);
			step_q         <= '0;
			pos_q          <= '0;
			sel_q          <= '0;
			out_valid_q    <= 1'b0;
			bcd_digit_q    <= '0;
			digit_select_q <= '0;
			too_large_q    <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dc_q <= cfg_wr_data;
			end
			// in the strobe phase a free output register is always refilled below
			if (out_valid_q && !out_stall && state_q != ST_SHOW) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						step_q  <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == mbcd_pkg::STEP_W'(mbcd_pkg::STEPS - 1)) begin
						pos_q   <= mbcd_pkg::IDX_W'(n_eff - 1'b1);
						sel_q   <= '0;
						state_q <= ST_SHOW;
					end
				end
				ST_SHOW: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (big) begin
							bcd_digit_q    <= '0;
							digit_select_q <= '0;
							too_large_q    <= 1'b1;
							last_q         <= 1'b1;
							state_q        <= ST_IDLE;
						end else begin
							bcd_digit_q    <= digits[pos_q];
							digit_select_q <= sel_q;
							too_large_q    <= 1'b0;
							last_q         <= (pos_q == '0);
							pos_q          <= pos_q - 1'b1;
							sel_q          <= sel_q + 1'b1;
							if (pos_q == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign bcd_digit    = bcd_digit_q;
	assign digit_select = digit_select_q;
	assign too_large    = too_large_q;
	assign last         = last_q;

endmodule
`default_nettype wire

/* rtl/mbcd_checker.sv */
// Port-level checks for the multiplexed BCD display driver, bound to the top.
// Depends on mbcd_pkg and multiplexed_bcd_display_driver.
`default_nettype none
module mbcd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [mbcd_pkg::NIB_W-1:0]    bcd_digit,
	input wire logic [mbcd_pkg::SEL_W-1:0]    digit_select,
	input wire logic                          too_large,
	input wire logic                          last
);

	// after a transfer the driver leaves ST_IDLE to convert, so transfers never come back to back
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken in the cycle after a transfer");

	a_bcd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !too_large) |-> (bcd_digit <= mbcd_pkg::nib_t'(9)))
		else $error("digit out of BCD range");

	a_overflow_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && too_large) |-> (last && digit_select == '0 && bcd_digit == '0))
		else $error("overflow result malformed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(bcd_digit)
			&& $stable(digit_select) && $stable(too_large) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind multiplexed_bcd_display_driver mbcd_checker u_mbcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.bcd_digit    (bcd_digit),
	.digit_select (digit_select),
	.too_large    (too_large),
	.last         (last)
);
`default_nettype wire
